FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/pss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the plucked-string synthesizer.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int MAX_PERIOD = 2048;
  localparam int ADDR_W     = $clog2(MAX_PERIOD);
  localparam int PERIOD_W   = 12;
  localparam int LEN_W      = (ADDR_W + 1 > PERIOD_W) ? ADDR_W + 1 : PERIOD_W;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int SEED_W     = 16;
  localparam int TICK_W     = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
  localparam logic [GAIN_W-1:0]   DECAY_RESET  = GAIN_W'(65274);
  localparam logic [SEED_W-1:0]   SEED_RESET   = SEED_W'(44257);
  localparam logic [SEED_W-1:0]   LFSR_TAPS    = 16'hB400;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_PLUCK = 2'd1,
    MODE_LOAD  = 2'd2
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_DECAY  = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PLUCK,
    OP_LOAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

FILE: sv/plucked_string_synth_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plucked_string_synth_unit
// Karplus-Strong plucked-string generator with a configurable ring delay line.
// ----------------------------------------------------------------------------
// After reset the block clears its 2048-entry delay line, one entry per cycle,
// and in_tready stays low until that is done; configuration writes are taken
// throughout. Commands are queued two deep, then run by a sequencer that owns
// the single-write, single-read delay line memory. For a tick the sequencer
// makes two registered memory reads, forms the magnitude, does the decay
// multiply and writes back; a load writes one entry, an unused mode writes
// nothing, and a pluck fills the effective ring length with noise, one sample
// written per cycle. Each command gives one transaction on the out_ channel.
module plucked_string_synth_unit
  import pss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] load_value
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [15:0] sample_out, [47:16] tick_count
);

  q_entry_t     push_entry, head_entry;
  q_status_t    q_status;
  back_status_t back_status;
  logic         push, pop;

  pss_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_status    (q_status),
    .back_status (back_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  pss_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  pss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_entry    (head_entry),
    .q_status   (q_status),
    .q_pop      (pop),
    .status     (back_status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sv/pss_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_fifo
// Short command queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module pss_fifo
  import pss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head_entry,
  output q_status_t status
);

  q_entry_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_entry   = slot_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/pss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_front
// Input handshake and mode decode into queue commands.
// ----------------------------------------------------------------------------
module pss_front
  import pss_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [MODE_W-1:0]    in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  q_status_t            q_status,
  input  back_status_t         back_status,
  output logic                 push,
  output q_entry_t             push_entry
);

  // no transactions while the delay line is being cleared
  assign in_tready = !q_status.full && !back_status.clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_entry.value = in_tdata[SAMPLE_W-1:0];
    unique case (in_tuser)
      MODE_TICK:  push_entry.op = OP_TICK;
      MODE_PLUCK: push_entry.op = OP_PLUCK;
      MODE_LOAD:  push_entry.op = OP_LOAD;
      default:    push_entry.op = OP_NOP;
    endcase
  end

endmodule

FILE: sv/pss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_back
// Sequencer: delay line memory, tick datapath, noise fill, config, result.
// ----------------------------------------------------------------------------
module pss_back
  import pss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  q_entry_t              q_entry,
  input  q_status_t             q_status,
  output logic                  q_pop,
  output back_status_t          status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_TK_B = 8'b0000_0100,
    S_TK_M = 8'b0000_1000,
    S_TK_P = 8'b0001_0000,
    S_TK_W = 8'b0010_0000,
    S_FILL = 8'b0100_0000,
    S_RD   = 8'b1000_0000
  } state_t;

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] r);
    logic [SEED_W-1:0] s;
    s = r >> 1;
    if (r[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  logic [SAMPLE_W-1:0] mem [MAX_PERIOD];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [GAIN_W-1:0]   decay_r, decay_nxt;
  logic [SEED_W-1:0]   noise_r, noise_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]   next_r, next_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [SAMPLE_W-1:0] a_r, a_nxt;
  logic [SAMPLE_W-1:0] b_r, b_nxt;
  logic [SAMPLE_W:0]   mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [SAMPLE_W-1:0] prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [TICK_W-1:0]   out_tick_r;

  logic [LEN_W-1:0]    period_ext, len;
  logic [ADDR_W-1:0]   head_eff, next_eff;
  logic [LEN_W-1:0]    next_wide;
  logic signed [SAMPLE_W:0] sum;
  logic [SAMPLE_W+GAIN_W:0] prod_full;
  logic                emit;
  logic [SAMPLE_W-1:0] emit_sample;
  logic [TICK_W-1:0]   emit_tick;
  logic                fill_last;

  assign period_ext = LEN_W'(period_r);
  assign len = (period_ext < LEN_W'(2))          ? LEN_W'(2) :
               (period_ext > LEN_W'(MAX_PERIOD)) ? LEN_W'(MAX_PERIOD) : period_ext;

  assign head_eff  = (LEN_W'(head_r) >= len) ? '0 : head_r;
  assign next_wide = LEN_W'(head_eff) + 1'b1;
  assign next_eff  = (next_wide >= len) ? '0 : next_wide[ADDR_W-1:0];

  assign sum       = {a_r[SAMPLE_W-1], a_r} + {rd_data_r[SAMPLE_W-1], rd_data_r};
  assign prod_full = (SAMPLE_W+GAIN_W+1)'(mag_r) * (SAMPLE_W+GAIN_W+1)'(decay_r);
  assign fill_last = (LEN_W'(idx_r) == len - 1'b1);

  assign status.clearing = (state_r == S_CLR);
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {out_tick_r, out_sample_r};

  always_comb begin
    state_nxt   = state_r;
    period_nxt  = period_r;
    decay_nxt   = decay_r;
    noise_nxt   = noise_r;
    head_nxt    = head_r;
    idx_nxt     = idx_r;
    next_nxt    = next_r;
    ticks_nxt   = ticks_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    prod_nxt    = prod_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = '0;
    mem_raddr   = head_eff;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_sample = rd_data_r;
    emit_tick   = ticks_r;

    unique case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == ADDR_W'(MAX_PERIOD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_status.empty && (!out_valid_r || out_tready)) begin
          q_pop    = 1'b1;
          head_nxt = head_eff;
          case (q_entry.op)
            OP_TICK: begin
              next_nxt  = next_eff;
              state_nxt = S_TK_B;
            end
            OP_PLUCK: begin
              idx_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = head_eff;
              mem_wdata = q_entry.value;
              head_nxt  = next_eff;
              mem_raddr = next_eff;
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_RD;
            end
          endcase
        end
      end
      S_TK_B: begin
        a_nxt     = rd_data_r;
        mem_raddr = next_r;
        state_nxt = S_TK_M;
      end
      S_TK_M: begin
        b_nxt     = rd_data_r;
        neg_nxt   = sum[SAMPLE_W];
        mag_nxt   = sum[SAMPLE_W] ? (SAMPLE_W+1)'(-sum) : (SAMPLE_W+1)'(sum);
        state_nxt = S_TK_P;
      end
      S_TK_P: begin
        prod_nxt  = prod_full[SAMPLE_W+GAIN_W:GAIN_W+1];
        state_nxt = S_TK_W;
      end
      S_TK_W: begin
        mem_we      = 1'b1;
        mem_waddr   = head_r;
        mem_wdata   = neg_r ? SAMPLE_W'(-prod_r) : prod_r;
        head_nxt    = next_r;
        ticks_nxt   = ticks_r + 1'b1;
        emit        = 1'b1;
        emit_sample = b_r;
        emit_tick   = ticks_nxt;
        state_nxt   = S_IDLE;
      end
      S_FILL: begin
        noise_nxt = lfsr_step(noise_r);
        mem_we    = 1'b1;
        mem_wdata = noise_nxt;
        if (idx_r == head_r) begin
          b_nxt = noise_nxt;
        end
        idx_nxt = idx_r + 1'b1;
        if (fill_last) begin
          emit        = 1'b1;
          emit_sample = b_nxt;
          state_nxt   = S_IDLE;
        end
      end
      S_RD: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_addr)
        CFG_PERIOD: period_nxt = cfg_wdata[PERIOD_W-1:0];
        CFG_DECAY:  decay_nxt  = cfg_wdata[GAIN_W-1:0];
        CFG_SEED:   noise_nxt  = (cfg_wdata[SEED_W-1:0] == '0) ? SEED_W'(1)
                                                               : cfg_wdata[SEED_W-1:0];
        default: ;
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      period_r    <= PERIOD_RESET;
      decay_r     <= DECAY_RESET;
      noise_r     <= SEED_RESET;
      head_r      <= '0;
      idx_r       <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      decay_r     <= decay_nxt;
      noise_r     <= noise_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_r <= next_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    if (emit) begin
      out_sample_r <= emit_sample;
      out_tick_r   <= emit_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

FILE: sv/pss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks of the plucked-string synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pss_checker
  import pss_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [2:0]        pend_r;
  logic [TICK_W-1:0] last_tick_r;
  logic              have_last_r;
  logic              in_xfer, out_xfer;
  logic [TICK_W-1:0] tick;
  logic              tick_ok;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign tick     = out_tdata[OUT_DATA_W-1:SAMPLE_W];
  assign tick_ok  = (tick == last_tick_r) || (tick == last_tick_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      have_last_r <= 1'b0;
    end else begin
      pend_r <= pend_r + 3'(in_xfer) - 3'(out_xfer);
      if (out_xfer) begin
        have_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      last_tick_r <= tick;
    end
  end

  `ASSERT_IMPLIES(a_clear_blocks_input, $rose(rst_n), !in_tready)
  `ASSERT_IMPLIES(a_no_invented_result, out_tvalid, pend_r != 3'd0)
  `ASSERT_ALWAYS(a_inflight_bound, pend_r <= 3'd3)
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPLIES(a_tick_step, out_xfer && have_last_r, tick_ok)

endmodule

bind plucked_string_synth_unit pss_checker u_pss_checker (.*);

FILE: tb/sv/plucked_string_synth_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plucked_string_synth_checker
// Watches the config port and both stream channels of the plucked-string
// synthesizer. Keeps its own copy of the delay line, noise LFSR and tick count,
// predicts the result of every accepted input transaction, and compares each
// output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module plucked_string_synth_checker
  import pss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] load_value
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] sample_out, [47:16] tick_count
  output int unsigned           error_count,
  output int unsigned           pending_count
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TICK_W-1:0]   ticks;
  } string_out_t;

  logic signed [SAMPLE_W-1:0] ring [MAX_PERIOD];
  int unsigned                head_pos;
  logic [SEED_W-1:0]          noise_q;
  logic [TICK_W-1:0]          tick_total;
  logic [PERIOD_W-1:0]        period_reg;
  logic [GAIN_W-1:0]          gain_reg;
  string_out_t                expected_samples [$];

  function automatic string_out_t advance_string(input logic [MODE_W-1:0]   mode_sel,
                                                 input logic [SAMPLE_W-1:0] value);
    int unsigned len;
    int unsigned nxt;
    int unsigned idx;
    int          total;
    int          mag;
    logic [47:0] scaled;
    string_out_t res;
    len = (period_reg < 2) ? 2 : ((period_reg > MAX_PERIOD) ? MAX_PERIOD : period_reg);
    // ring shrank below the head
    if (head_pos >= len) head_pos = 0;
    case (mode_sel)
      MODE_TICK: begin
        nxt = (head_pos + 1 >= len) ? 0 : head_pos + 1;
        total = int'(ring[head_pos]) + int'(ring[nxt]);
        mag = (total < 0) ? -total : total;
        // halve and scale in one shift, truncating the magnitude
        scaled = (48'(mag) * 48'(gain_reg)) >> 17;
        ring[head_pos] = (total < 0) ? -$signed(scaled[15:0]) : $signed(scaled[15:0]);
        head_pos = nxt;
        tick_total = tick_total + 1'b1;
      end
      MODE_PLUCK: begin
        for (idx = 0; idx < len; idx++) begin
          noise_q = {1'b0, noise_q[SEED_W-1:1]} ^ (noise_q[0] ? LFSR_TAPS : '0);
          ring[idx] = noise_q;
        end
      end
      MODE_LOAD: begin
        ring[head_pos] = value;
        head_pos = (head_pos + 1 >= len) ? 0 : head_pos + 1;
      end
      default: ;
    endcase
    res.sample = ring[head_pos];
    res.ticks  = tick_total;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    string_out_t got;
    string_out_t want;
    if (!rst_n) begin
      foreach (ring[i]) ring[i] = '0;
      head_pos   = 0;
      period_reg = PERIOD_RESET;
      gain_reg   = DECAY_RESET;
      noise_q    = SEED_RESET;
      tick_total = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PERIOD: period_reg = cfg_wdata[PERIOD_W-1:0];
          CFG_DECAY:  gain_reg   = cfg_wdata[GAIN_W-1:0];
          CFG_SEED:   noise_q    = (cfg_wdata[SEED_W-1:0] == '0) ? SEED_W'(1)
                                                                 : cfg_wdata[SEED_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_samples.push_back(advance_string(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.sample = out_tdata[15:0];
        got.ticks  = out_tdata[47:16];
        if (expected_samples.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected output sample %0d tick %0d", $realtime,
                     $signed(got.sample), got.ticks);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample) begin
            if (error_count < 10)
              $display("%0t: sample_out expected %0d got %0d", $realtime,
                       $signed(want.sample), $signed(got.sample));
            error_count++;
          end
          if (got.ticks !== want.ticks) begin
            if (error_count < 10)
              $display("%0t: tick_count expected %0d got %0d", $realtime,
                       want.ticks, got.ticks);
            error_count++;
          end
        end
      end
    end
    pending_count = expected_samples.size();
  end

endmodule

FILE: tb/sv/tb_plucked_string_synth_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plucked_string_synth_unit
// Drives the plucked-string synthesizer with a short directed sequence (sample
// extremes, every mode, short/long/out-of-range ring lengths, zero seed, head
// past a shrunk ring) and then random phases of plucks, loads and ticks under
// changing settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_plucked_string_synth_unit;
  import pss_pkg::*;

  localparam int unsigned          STALL_LIMIT = 20000;
  localparam int unsigned          ITEM_TARGET = 1250;
  localparam logic [MODE_W-1:0]     MODE_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE   = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int unsigned           error_count;
  int unsigned           pending_count;
  int unsigned           quiet_cycles;
  logic                  steady_run;
  logic [PERIOD_W-1:0]   cur_period;

  plucked_string_synth_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  plucked_string_synth_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= steady_run || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [MODE_W-1:0] mode_sel, input logic [IN_DATA_W-1:0] value);
    while (!steady_run && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode_sel;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every predicted sample has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // mask: [0] period, [1] decay, [2] seed, [3] spare index
  task automatic apply_settings(input logic [3:0] mask, input logic [15:0] period_word,
                                input logic [15:0] gain, input logic [15:0] seed);
    if (mask[0]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_PERIOD;
      cfg_wdata <= period_word;
      cur_period = period_word[PERIOD_W-1:0];
      @(negedge clk);
    end
    if (mask[1]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_DECAY;
      cfg_wdata <= gain;
      @(negedge clk);
    end
    if (mask[2]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_SEED;
      cfg_wdata <= seed;
      @(negedge clk);
    end
    if (mask[3]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_SPARE;
      cfg_wdata <= 16'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(output int unsigned counted);
    int unsigned       pick;
    int unsigned       n_items;
    int unsigned       pattern;
    int unsigned       len;
    int unsigned       fill;
    logic [15:0]       period_word;
    logic [15:0]       gain;
    logic [15:0]       seed;
    logic [3:0]        mask;
    logic [MODE_W-1:0] mode_sel;
    counted = 0;
    pick = $urandom_range(99);
    if (pick < 60)      period_word = 16'($urandom_range(24, 2));
    else if (pick < 75) period_word = 16'($urandom_range(300, 25));
    else if (pick < 85) begin
      case ($urandom_range(3))
        0: period_word = 16'd0;
        1: period_word = 16'd1;
        2: period_word = 16'd2;
        default: period_word = 16'(MAX_PERIOD);
      endcase
    end
    else if (pick < 92) period_word = 16'($urandom_range(4095, 2049));
    else                period_word = 16'($urandom_range(2047, 301));
    period_word[15:12] = 4'($urandom);
    pick = $urandom_range(99);
    if (pick < 15)      gain = 16'd0;
    else if (pick < 30) gain = 16'hFFFF;
    else if (pick < 60) gain = 16'($urandom_range(65535, 60000));
    else                gain = 16'($urandom);
    seed = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    mask = {($urandom_range(9) == 0), 3'($urandom_range(7, 1))};
    apply_settings(mask, period_word, gain, seed);

    len = (cur_period < 2) ? 2 : ((cur_period > MAX_PERIOD) ? MAX_PERIOD : cur_period);
    fill = (len < 30) ? len : 30;
    n_items = $urandom_range(80, 20);
    pattern = $urandom_range(2);
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(9) == 0) begin
        mode_sel = MODE_W'($urandom_range(3));
      end else begin
        case (pattern)
          0: mode_sel = (k == 0) ? MODE_PLUCK : MODE_TICK;
          1: mode_sel = (k < fill) ? MODE_LOAD : MODE_TICK;
          default: begin
            pick = $urandom_range(99);
            if (pick < 55)      mode_sel = MODE_TICK;
            else if (pick < 65) mode_sel = MODE_PLUCK;
            else                mode_sel = MODE_LOAD;
          end
        endcase
      end
      send_cmd(mode_sel, 16'($urandom));
      if (mode_sel != MODE_UNUSED) counted++;
    end
  endtask

  initial begin
    int unsigned items_sent;
    int unsigned phase_idx;
    int unsigned n_done;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_PERIOD;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_TICK;
    out_tready = 1'b0;
    steady_run = 1'b0;
    cur_period = PERIOD_RESET;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every mode, clamped lengths, zero seed, stale head
    send_cmd(MODE_TICK, 16'h0000);
    send_cmd(MODE_LOAD, 16'h8000);
    send_cmd(MODE_LOAD, 16'h8000);
    send_cmd(MODE_LOAD, 16'h7FFF);
    send_cmd(MODE_LOAD, 16'h7FFF);
    send_cmd(MODE_LOAD, 16'hFFFF);
    send_cmd(MODE_LOAD, 16'h0001);
    send_cmd(MODE_UNUSED, 16'hA5A5);
    drain();
    apply_settings(4'b1011, 16'd4, 16'hFFFF, 16'd0);
    repeat (4) send_cmd(MODE_TICK, 16'h5A5A);
    drain();
    apply_settings(4'b0111, 16'd1, 16'd0, 16'd0);
    send_cmd(MODE_PLUCK, 16'hFFFF);
    send_cmd(MODE_TICK, 16'h0000);
    send_cmd(MODE_TICK, 16'hFFFF);
    drain();
    apply_settings(4'b0111, 16'hFFFF, DECAY_RESET, 16'hFFFF);
    send_cmd(MODE_PLUCK, 16'h0000);
    send_cmd(MODE_TICK, 16'h0000);
    send_cmd(MODE_LOAD, 16'h1234);
    send_cmd(MODE_TICK, 16'h0000);
    drain();
    apply_settings(4'b0001, 16'd0, 16'd0, 16'd0);
    send_cmd(MODE_TICK, 16'h0000);
    send_cmd(MODE_PLUCK, 16'h0000);
    drain();

    items_sent = 0;
    phase_idx  = 0;
    while (items_sent < ITEM_TARGET) begin
      steady_run <= (phase_idx >= 6 && phase_idx < 10);
      run_phase(n_done);
      items_sent += n_done;
      drain();
      phase_idx++;
    end

    repeat (64) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/pss_pkg.sv
sv/pss_fifo.sv
sv/pss_front.sv
sv/pss_back.sv
sv/plucked_string_synth_unit.sv
sv/pss_checker.sv
tb/sv/plucked_string_synth_checker.sv
tb/sv/tb_plucked_string_synth_unit.sv
